// ----- sv/cmk_pkg.sv -----
// ----------------------------------------------------------------------------
// cmk_pkg
// Shared types and constants of the confusion matrix / kappa accumulator.
// ----------------------------------------------------------------------------
package cmk_pkg;

  typedef enum logic [1:0] {
    OP_ACCUM  = 2'd0,
    OP_READ   = 2'd1,
    OP_FINISH = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_READ_RD,
    ST_READ_WAIT,
    ST_FIN_CLS,
    ST_FIN_ROW,
    ST_FIN_COL,
    ST_FIN_SUMS,
    ST_RATIO_DONE,
    ST_MAC_DONE,
    ST_AVG,
    ST_AVG_DONE,
    ST_OA,
    ST_OA_DONE,
    ST_TT_DONE,
    ST_HT_DONE,
    ST_KAP_DONE,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_t;

  localparam int          QUO_BITS  = 18;
  localparam logic [16:0] Q_ONE     = 17'h10000;
  localparam logic [23:0] OUT24_MAX = 24'hFFFFFF;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 136;

  // result beat layout
  localparam int O_CELL_LSB = 0;
  localparam int O_COLP     = 24;
  localparam int O_CC_LSB   = 25;
  localparam int O_HIT_LSB  = 29;
  localparam int O_TOT_LSB  = 53;
  localparam int O_OA_LSB   = 77;
  localparam int O_AA_LSB   = 94;
  localparam int O_KAP_LSB  = 111;
  localparam int O_KV       = 129;

endpackage

// ----- sv/confusion_matrix_kappa_accumulator.sv -----
// ----------------------------------------------------------------------------
// confusion_matrix_kappa_accumulator
// Confusion matrix in block RAM with a serial multiplier / divider sequencer
// for the finish report (accuracies and Cohen's kappa in Q1.16, kappa signed).
// ----------------------------------------------------------------------------
// Flow: a counted accumulate reads the cell and writes it back incremented, a read
//   reads the cell and waits for the RAM output, a dropped pixel goes straight to
//   the result; clear walks every RAM address, and finish runs the one-bit-per-cycle
//   mul/div unit for each present class. One item is taken at a time; the next
//   beat is taken while a result still waits.
// Reset: synchronous; a clearing pass over every RAM address zeroes the RAM, s_tready low.
module confusion_matrix_kappa_accumulator
  import cmk_pkg::*;
#(
  parameter int NUM_LABELS = 16,
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // predicted_label, reference_label, skip_pixel, read_row, read_col
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // opcode
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // cell_count, column_present, class_count, hit_count, total_count,
  // overall_accuracy, average_accuracy, kappa, kappa_valid
  output logic [OUT_DATA_W-1:0] m_tdata,
  // report_valid
  output logic                  m_tuser
);

  localparam int LBL_BITS  = (NUM_LABELS > 2) ? $clog2(NUM_LABELS) : 1;
  localparam int ADDR_BITS = 2 * LBL_BITS;
  localparam int DEPTH     = 1 << ADDR_BITS;
  localparam int SUM_BITS  = COUNT_BITS + 2 * LBL_BITS;
  localparam int PROD_BITS = 2 * SUM_BITS;
  localparam int DIV_BITS  = PROD_BITS + 19;
  localparam int ACC_BITS  = 17 + LBL_BITS;
  localparam int CC_BITS   = LBL_BITS + 1;
  localparam int STEP_BITS = $clog2(SUM_BITS) + 1;
  localparam logic [COUNT_BITS-1:0] CELL_MAX = {COUNT_BITS{1'b1}};

  function automatic logic [23:0] sat_sum(input logic [SUM_BITS-1:0] v);
    logic [SUM_BITS+23:0] w;
    w = (SUM_BITS+24)'(v);
    return (w > (SUM_BITS+24)'(OUT24_MAX)) ? OUT24_MAX : w[23:0];
  endfunction

  function automatic logic [23:0] sat_cell(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+23:0] w;
    w = (COUNT_BITS+24)'(v);
    return (w > (COUNT_BITS+24)'(OUT24_MAX)) ? OUT24_MAX : w[23:0];
  endfunction

  function automatic logic [16:0] cap_q(input logic [QUO_BITS-1:0] q);
    return (q > QUO_BITS'(Q_ONE)) ? Q_ONE : q[16:0];
  endfunction

  function automatic logic lbl_ok(input logic [3:0] v);
    return 32'(v) < 32'(NUM_LABELS);
  endfunction

  state_t state, state_next, ret;

  logic [COUNT_BITS-1:0] mem [0:DEPTH-1];
  logic [COUNT_BITS-1:0] mem_q;
  logic [ADDR_BITS-1:0]  rd_addr, wr_addr;
  logic                  wr_en;
  logic [COUNT_BITS-1:0] wr_data;

  logic [NUM_LABELS-1:0] present;
  logic [ADDR_BITS-1:0]  ptr;
  logic                  clr_op;
  logic [LBL_BITS-1:0]   pred_r, ref_r, rr_r, rc_r;
  logic [LBL_BITS:0]     idx, jdx;
  logic [LBL_BITS-1:0]   rd_j;
  logic                  rd_pend;
  logic [SUM_BITS-1:0]   row_sum, col_sum, hits, total;
  logic [COUNT_BITS-1:0] diag;
  logic [ACC_BITS-1:0]   acc_sum;
  logic [CC_BITS-1:0]    cc;
  logic [PROD_BITS-1:0]  s_acc, kden;
  logic                  kneg;

  logic [PROD_BITS-1:0]  mul_x, mul_p;
  logic [SUM_BITS-1:0]   mul_y;
  logic [DIV_BITS-1:0]   div_a, div_bs;
  logic [QUO_BITS-1:0]   div_q;
  logic [STEP_BITS-1:0]  step;

  logic [23:0]           cell_r;
  logic                  colp_r, report_r, kvalid_r;
  logic [16:0]           oa_r, aa_r;
  logic signed [17:0]    kap_r;

  logic                  s_fire, in_ok, jdx_lt, div_big, p_ge_s;
  logic [LBL_BITS-1:0]   in_pred, in_ref, in_rr, in_rc;
  logic [PROD_BITS-1:0]  div_num, div_den, diff_abs, mul_a;
  logic [SUM_BITS-1:0]   mul_b;
  logic [DIV_BITS-1:0]   div_sub;
  logic [16:0]           q_capped;

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign in_pred  = LBL_BITS'(s_tdata[3:0]);
  assign in_ref   = LBL_BITS'(s_tdata[7:4]);
  assign in_rr    = LBL_BITS'(s_tdata[12:9]);
  assign in_rc    = LBL_BITS'(s_tdata[16:13]);
  assign in_ok    = (s_tdata[7:4] != 4'd0) && lbl_ok(s_tdata[7:4]) && lbl_ok(s_tdata[3:0]);
  assign jdx_lt   = 32'(jdx) < 32'(NUM_LABELS);
  assign p_ge_s   = mul_p >= s_acc;
  assign diff_abs = p_ge_s ? (mul_p - s_acc) : (s_acc - mul_p);
  assign div_sub  = div_a - div_bs;
  assign q_capped = cap_q(div_q);

  always_comb begin
    div_num = '0;
    div_den = '0;
    mul_a   = '0;
    mul_b   = '0;
    unique case (state)
      ST_FIN_SUMS: begin
        div_num = PROD_BITS'(diag);
        div_den = PROD_BITS'(row_sum + SUM_BITS'(0));
      end
      ST_OA: begin
        div_num = PROD_BITS'(hits);
        div_den = PROD_BITS'(total);
      end
      ST_HT_DONE: begin
        div_num = diff_abs;
        div_den = kden;
      end
      ST_RATIO_DONE: begin
        mul_a = PROD_BITS'(row_sum);
        mul_b = col_sum;
      end
      ST_OA_DONE: begin
        mul_a = PROD_BITS'(total);
        mul_b = total;
      end
      ST_TT_DONE: begin
        mul_a = PROD_BITS'(hits);
        mul_b = total;
      end
      default: ;
    endcase
  end
  assign div_big = div_num >= div_den;

  // RAM ports
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = ptr;
      end
      ST_ACC_RD:  rd_addr = {pred_r, ref_r};
      ST_ACC_WR: begin
        wr_en   = (mem_q != CELL_MAX);
        wr_addr = {pred_r, ref_r};
        wr_data = mem_q + COUNT_BITS'(1);
      end
      ST_READ_RD: rd_addr = {rr_r, rc_r};
      ST_FIN_ROW: rd_addr = {idx[LBL_BITS-1:0], jdx[LBL_BITS-1:0]};
      ST_FIN_COL: rd_addr = {jdx[LBL_BITS-1:0], idx[LBL_BITS-1:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (ptr == ADDR_BITS'(DEPTH - 1)) begin
          state_next = clr_op ? ST_OUT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_fire) begin
          unique case (opcode_t'(s_tuser))
            OP_ACCUM:  state_next = (in_ok && !s_tdata[8]) ? ST_ACC_RD : ST_OUT;
            OP_READ:   state_next = (lbl_ok(s_tdata[12:9]) && lbl_ok(s_tdata[16:13])) ?
                                    ST_READ_RD : ST_OUT;
            OP_FINISH: state_next = ST_FIN_CLS;
            OP_CLEAR:  state_next = ST_CLEAR;
          endcase
        end
      end
      ST_ACC_RD:    state_next = ST_ACC_WR;
      ST_ACC_WR:    state_next = ST_OUT;
      ST_READ_RD:   state_next = ST_READ_WAIT;
      ST_READ_WAIT: state_next = ST_OUT;
      ST_FIN_CLS: begin
        if (32'(idx) == 32'(NUM_LABELS)) begin
          state_next = ST_AVG;
        end else if (present[idx[LBL_BITS-1:0]]) begin
          state_next = ST_FIN_ROW;
        end
      end
      ST_FIN_ROW: if (!jdx_lt && !rd_pend) state_next = ST_FIN_COL;
      ST_FIN_COL: if (!jdx_lt && !rd_pend) state_next = ST_FIN_SUMS;
      ST_FIN_SUMS: begin
        if (row_sum == '0) state_next = ST_FIN_CLS;
        else               state_next = div_big ? ST_RATIO_DONE : ST_DIV;
      end
      ST_RATIO_DONE: state_next = ST_MUL;
      ST_MAC_DONE:   state_next = ST_FIN_CLS;
      ST_AVG:        state_next = (cc != '0) ? ST_DIV : ST_OA;
      ST_AVG_DONE:   state_next = ST_OA;
      ST_OA: begin
        if (total == '0) state_next = ST_OUT;
        else             state_next = div_big ? ST_OA_DONE : ST_DIV;
      end
      ST_OA_DONE:  state_next = ST_MUL;
      ST_TT_DONE:  state_next = ST_MUL;
      ST_HT_DONE: begin
        if (kden == '0) state_next = ST_OUT;
        else            state_next = div_big ? ST_KAP_DONE : ST_DIV;
      end
      ST_KAP_DONE: state_next = ST_OUT;
      ST_DIV: if (step == STEP_BITS'(QUO_BITS - 1)) state_next = ret;
      ST_MUL: if (step == STEP_BITS'(SUM_BITS - 1)) state_next = ret;
      ST_OUT: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      present  <= '0;
      ptr      <= '0;
      clr_op   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        ptr <= ptr + ADDR_BITS'(1);
      end
      if (s_fire) begin
        if (opcode_t'(s_tuser) == OP_ACCUM && in_ok) begin
          present[in_ref] <= 1'b1;
        end
        if (opcode_t'(s_tuser) == OP_CLEAR) begin
          present <= '0;
          ptr     <= '0;
          clr_op  <= 1'b1;
        end
      end
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output beat
  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {6'd0, kvalid_r, kap_r, aa_r, oa_r, sat_sum(total), sat_sum(hits),
                  4'(cc), colp_r, cell_r};
      m_tuser <= report_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          pred_r   <= in_pred;
          ref_r    <= in_ref;
          rr_r     <= in_rr;
          rc_r     <= in_rc;
          cell_r   <= '0;
          colp_r   <= 1'b0;
          report_r <= (opcode_t'(s_tuser) == OP_FINISH);
          cc       <= '0;
          hits     <= '0;
          total    <= '0;
          acc_sum  <= '0;
          s_acc    <= '0;
          oa_r     <= '0;
          aa_r     <= '0;
          kap_r    <= '0;
          kvalid_r <= 1'b0;
          idx      <= '0;
        end
      end
      ST_READ_WAIT: begin
        cell_r <= sat_cell(mem_q);
        colp_r <= present[rc_r];
      end
      ST_FIN_CLS: begin
        jdx     <= '0;
        rd_pend <= 1'b0;
        row_sum <= '0;
        col_sum <= '0;
        diag    <= '0;
        if (32'(idx) != 32'(NUM_LABELS) && !present[idx[LBL_BITS-1:0]]) begin
          idx <= idx + (LBL_BITS+1)'(1);
        end
      end
      ST_FIN_ROW, ST_FIN_COL: begin
        rd_pend <= jdx_lt;
        if (jdx_lt) begin
          jdx  <= jdx + (LBL_BITS+1)'(1);
          rd_j <= jdx[LBL_BITS-1:0];
        end else if (!rd_pend) begin
          jdx <= '0;
        end
        if (rd_pend && present[rd_j]) begin
          if (state == ST_FIN_ROW) row_sum <= row_sum + SUM_BITS'(mem_q);
          else                     col_sum <= col_sum + SUM_BITS'(mem_q);
        end
        if (rd_pend && state == ST_FIN_ROW && rd_j == idx[LBL_BITS-1:0]) begin
          diag <= mem_q;
        end
      end
      ST_FIN_SUMS: begin
        hits  <= hits + SUM_BITS'(diag);
        total <= total + row_sum;
        cc    <= cc + CC_BITS'(1);
        ret   <= ST_RATIO_DONE;
        if (row_sum == '0) idx <= idx + (LBL_BITS+1)'(1);
      end
      ST_RATIO_DONE: begin
        acc_sum <= acc_sum + ACC_BITS'(q_capped);
        ret     <= ST_MAC_DONE;
      end
      ST_MAC_DONE: begin
        s_acc <= s_acc + mul_p;
        idx   <= idx + (LBL_BITS+1)'(1);
      end
      ST_AVG: begin
        div_a  <= DIV_BITS'(acc_sum) + DIV_BITS'(cc >> 1);
        div_bs <= DIV_BITS'(cc) << (QUO_BITS - 1);
        div_q  <= '0;
        step   <= '0;
        ret    <= ST_AVG_DONE;
      end
      ST_AVG_DONE: aa_r <= q_capped;
      ST_OA:       ret  <= ST_OA_DONE;
      ST_OA_DONE: begin
        oa_r <= q_capped;
        ret  <= ST_TT_DONE;
      end
      ST_TT_DONE: begin
        kden <= mul_p - s_acc;
        ret  <= ST_HT_DONE;
      end
      ST_HT_DONE: begin
        kneg <= !p_ge_s;
        ret  <= ST_KAP_DONE;
      end
      ST_KAP_DONE: begin
        kap_r    <= kneg ? -$signed(18'(q_capped)) : $signed(18'(q_capped));
        kvalid_r <= 1'b1;
      end
      ST_DIV: begin
        if (div_a >= div_bs) begin
          div_a <= div_sub;
          div_q <= {div_q[QUO_BITS-2:0], 1'b1};
        end else begin
          div_q <= {div_q[QUO_BITS-2:0], 1'b0};
        end
        div_bs <= div_bs >> 1;
        step   <= step + STEP_BITS'(1);
      end
      ST_MUL: begin
        if (mul_y[0]) mul_p <= mul_p + mul_x;
        mul_x <= mul_x << 1;
        mul_y <= mul_y >> 1;
        step  <= step + STEP_BITS'(1);
      end
      default: ;
    endcase

    // ratio load: a = num*2^17 + den, divisor 2*den aligned to the top quotient bit
    if (state == ST_FIN_SUMS || state == ST_OA || state == ST_HT_DONE) begin
      div_a  <= (DIV_BITS'(div_num) << 17) + DIV_BITS'(div_den);
      div_bs <= DIV_BITS'(div_den) << QUO_BITS;
      div_q  <= div_big ? QUO_BITS'(Q_ONE) : '0;
      step   <= '0;
    end
    if (state == ST_RATIO_DONE || state == ST_OA_DONE || state == ST_TT_DONE) begin
      mul_x <= mul_a;
      mul_y <= mul_b;
      mul_p <= '0;
      step  <= '0;
    end
  end

endmodule

// ----- sv/cmk_checker.sv -----
// ----------------------------------------------------------------------------
// cmk_checker
// Port-level assertions for the confusion matrix / kappa accumulator.
// ----------------------------------------------------------------------------
module cmk_checker
  import cmk_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second beat taken while busy");

  a_report_no_cell: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[O_COLP:O_CELL_LSB] == '0)
    else $error("report beat carries cell data");

  a_plain_no_report: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[O_KV:O_CC_LSB] == '0)
    else $error("report fields set on a non-report beat");

  a_kappa_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[O_KV] |-> m_tdata[O_KV-1:O_KAP_LSB] == '0)
    else $error("kappa nonzero while invalid");

endmodule

bind confusion_matrix_kappa_accumulator cmk_checker u_cmk_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- tb/sv/confusion_matrix_kappa_accumulator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// confusion_matrix_kappa_accumulator_test
// Drives label pairs, cell reads, finish and clear beats into the accumulator.
// A local confusion matrix model predicts every result beat, including the
// accuracies and kappa, under four idle/stall phases on both stream sides.
// ----------------------------------------------------------------------------
module confusion_matrix_kappa_accumulator_test;
  import cmk_pkg::*;

  localparam int NLAB       = 16;
  localparam int RAND_ITEMS = 1530;
  localparam int LIMIT      = 3000000;

  typedef struct packed {
    logic [23:0] cnt;
    logic        colp;
    logic [3:0]  cc;
    logic [23:0] hit;
    logic [23:0] tot;
    logic [16:0] oa;
    logic [16:0] aa;
    logic [17:0] kap;
    logic        kv;
    logic        rv;
  } report_t;

  typedef struct {
    opcode_t    op;
    logic [3:0] pred;
    logic [3:0] refl;
    logic       skip;
    logic [3:0] rr;
    logic [3:0] rc;
    bit         lit_en;
    logic [23:0] lit_cell;
    logic        lit_colp;
  } row_t;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  s_tvalid = 0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  logic [23:0] tally [NLAB*NLAB];
  logic [NLAB-1:0] seen_mask;
  report_t pending_reports[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  confusion_matrix_kappa_accumulator u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [16:0] q_frac(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    if (den == 0) return '0;
    if (num >= den) return Q_ONE;
    q = ((num << 17) + den) / (den << 1);
    return (q > Q_ONE) ? Q_ONE : q[16:0];
  endfunction

  function automatic report_t predict_report(opcode_t op, logic [3:0] pred, logic [3:0] refl,
                                             logic skip, logic [3:0] rr, logic [3:0] rc);
    report_t r;
    logic [127:0] rows [NLAB];
    logic [127:0] cols [NLAB];
    logic [127:0] hits, total, acc_sum, cc, s, d, p, avg;
    logic [16:0] kmag;
    r = '0;
    case (op)
      OP_ACCUM: begin
        if (refl != 0) begin
          seen_mask[refl] = 1'b1;
          if (!skip && tally[pred*NLAB+refl] != OUT24_MAX)
            tally[pred*NLAB+refl] = tally[pred*NLAB+refl] + 24'd1;
        end
      end
      OP_READ: begin
        r.cnt  = tally[rr*NLAB+rc];
        r.colp = seen_mask[rc];
      end
      OP_FINISH: begin
        hits = 0; total = 0; acc_sum = 0; cc = 0; s = 0;
        for (int i = 0; i < NLAB; i++) begin
          rows[i] = 0;
          cols[i] = 0;
          if (seen_mask[i]) begin
            cc++;
            for (int j = 0; j < NLAB; j++)
              if (seen_mask[j]) begin
                rows[i] += 128'(tally[i*NLAB+j]);
                cols[i] += 128'(tally[j*NLAB+i]);
              end
            hits += 128'(tally[i*NLAB+i]);
            total += rows[i];
          end
        end
        for (int i = 0; i < NLAB; i++)
          if (seen_mask[i]) begin
            if (rows[i] != 0) acc_sum += 128'(q_frac(128'(tally[i*NLAB+i]), rows[i]));
            s += rows[i] * cols[i];
          end
        if (cc != 0) begin
          avg  = (acc_sum + cc/2) / cc;
          r.aa = (avg > Q_ONE) ? Q_ONE : avg[16:0];
        end
        if (total != 0) begin
          r.oa = q_frac(hits, total);
          d = total * total - s;
          p = hits * total;
          if (d != 0) begin
            r.kv = 1'b1;
            if (p >= s) begin
              kmag = q_frac(p - s, d);
              r.kap = {1'b0, kmag};
            end else begin
              kmag = q_frac(s - p, d);
              r.kap = -{1'b0, kmag};
            end
          end
        end
        r.cc  = cc[3:0];
        r.hit = (hits > OUT24_MAX) ? OUT24_MAX : hits[23:0];
        r.tot = (total > OUT24_MAX) ? OUT24_MAX : total[23:0];
        r.rv  = 1'b1;
      end
      default: begin
        foreach (tally[k]) tally[k] = '0;
        seen_mask = '0;
      end
    endcase
    return r;
  endfunction

  // lit_en: literal cell/column flag replaces the predicted ones
  task automatic send_beat(row_t it);
    report_t r;
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= {7'd0, it.rc, it.rr, it.skip, it.refl, it.pred};
    do @(posedge clk); while (!s_tready);
    r = predict_report(it.op, it.pred, it.refl, it.skip, it.rr, it.rc);
    if (it.lit_en) begin
      r.cnt  = it.lit_cell;
      r.colp = it.lit_colp;
    end
    pending_reports.push_back(r);
  endtask

  always @(posedge clk) begin
    report_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.cnt  = m_tdata[O_CELL_LSB +: 24];
      got.colp = m_tdata[O_COLP];
      got.cc   = m_tdata[O_CC_LSB +: 4];
      got.hit  = m_tdata[O_HIT_LSB +: 24];
      got.tot  = m_tdata[O_TOT_LSB +: 24];
      got.oa   = m_tdata[O_OA_LSB +: 17];
      got.aa   = m_tdata[O_AA_LSB +: 17];
      got.kap  = m_tdata[O_KAP_LSB +: 18];
      got.kv   = m_tdata[O_KV];
      got.rv   = m_tuser;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result beat %h", $realtime, got);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (got.cnt !== want.cnt) begin
          $display("%0t: cell_count exp %0d got %0d", $realtime, want.cnt, got.cnt); errors++;
        end
        if (got.colp !== want.colp) begin
          $display("%0t: column_present exp %0d got %0d", $realtime, want.colp, got.colp);
          errors++;
        end
        if (got.cc !== want.cc) begin
          $display("%0t: class_count exp %0d got %0d", $realtime, want.cc, got.cc); errors++;
        end
        if (got.hit !== want.hit) begin
          $display("%0t: hit_count exp %0d got %0d", $realtime, want.hit, got.hit); errors++;
        end
        if (got.tot !== want.tot) begin
          $display("%0t: total_count exp %0d got %0d", $realtime, want.tot, got.tot); errors++;
        end
        if (got.oa !== want.oa) begin
          $display("%0t: overall_accuracy exp %0d got %0d", $realtime, want.oa, got.oa);
          errors++;
        end
        if (got.aa !== want.aa) begin
          $display("%0t: average_accuracy exp %0d got %0d", $realtime, want.aa, got.aa);
          errors++;
        end
        if (got.kap !== want.kap) begin
          $display("%0t: kappa exp %0d got %0d", $realtime, $signed(want.kap), $signed(got.kap));
          errors++;
        end
        if (got.kv !== want.kv) begin
          $display("%0t: kappa_valid exp %0d got %0d", $realtime, want.kv, got.kv); errors++;
        end
        if (got.rv !== want.rv) begin
          $display("%0t: report_valid exp %0d got %0d", $realtime, want.rv, got.rv); errors++;
        end
      end
    end
  end

  row_t directed [] = '{
    '{OP_READ,   4'd0,  4'd0,  1'b0, 4'd15, 4'd15, 1, 24'd0, 1'b0},
    '{OP_FINISH, 4'd0,  4'd0,  1'b0, 4'd0,  4'd0,  0, 24'd0, 1'b0},
    '{OP_ACCUM,  4'd15, 4'd15, 1'b0, 4'd0,  4'd0,  0, 24'd0, 1'b0},
    '{OP_ACCUM,  4'd15, 4'd15, 1'b0, 4'd0,  4'd0,  0, 24'd0, 1'b0},
    '{OP_READ,   4'd0,  4'd0,  1'b0, 4'd15, 4'd15, 1, 24'd2, 1'b1},
    '{OP_FINISH, 4'd0,  4'd0,  1'b0, 4'd0,  4'd0,  0, 24'd0, 1'b0},
    '{OP_ACCUM,  4'd3,  4'd0,  1'b0, 4'd0,  4'd0,  0, 24'd0, 1'b0},
    '{OP_READ,   4'd0,  4'd0,  1'b0, 4'd3,  4'd0,  1, 24'd0, 1'b0},
    '{OP_ACCUM,  4'd1,  4'd2,  1'b1, 4'd0,  4'd0,  0, 24'd0, 1'b0},
    '{OP_READ,   4'd0,  4'd0,  1'b0, 4'd1,  4'd2,  1, 24'd0, 1'b1},
    '{OP_ACCUM,  4'd7,  4'd1,  1'b0, 4'd0,  4'd0,  0, 24'd0, 1'b0},
    '{OP_ACCUM,  4'd1,  4'd2,  1'b0, 4'd0,  4'd0,  0, 24'd0, 1'b0},
    '{OP_ACCUM,  4'd2,  4'd1,  1'b0, 4'd0,  4'd0,  0, 24'd0, 1'b0},
    '{OP_FINISH, 4'd0,  4'd0,  1'b0, 4'd0,  4'd0,  0, 24'd0, 1'b0},
    '{OP_ACCUM,  4'd7,  4'd7,  1'b0, 4'd0,  4'd0,  0, 24'd0, 1'b0},
    '{OP_FINISH, 4'd15, 4'd15, 1'b1, 4'd15, 4'd15, 0, 24'd0, 1'b0},
    '{OP_CLEAR,  4'd15, 4'd15, 1'b1, 4'd15, 4'd15, 0, 24'd0, 1'b0},
    '{OP_READ,   4'd0,  4'd0,  1'b0, 4'd15, 4'd15, 1, 24'd0, 1'b0},
    '{OP_ACCUM,  4'd5,  4'd9,  1'b0, 4'd0,  4'd0,  0, 24'd0, 1'b0},
    '{OP_FINISH, 4'd0,  4'd0,  1'b0, 4'd0,  4'd0,  0, 24'd0, 1'b0},
    '{OP_CLEAR,  4'd0,  4'd0,  1'b0, 4'd0,  4'd0,  0, 24'd0, 1'b0}
  };

  initial begin
    row_t it;
    int sel, nlab;
    foreach (tally[k]) tally[k] = '0;
    seen_mask = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_beat(directed[i]);
    nlab = 4;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      case (n * 4 / RAND_ITEMS)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      it.lit_en = 0;
      it.pred = 4'($urandom_range(0, 15));
      it.refl = 4'($urandom_range(0, 15));
      it.skip = ($urandom_range(99) < 10);
      it.rr   = 4'($urandom_range(0, 15));
      it.rc   = 4'($urandom_range(0, 15));
      sel = $urandom_range(999);
      if (sel < 800) begin
        it.op = OP_ACCUM;
        if ($urandom_range(99) < 90) it.refl = 4'($urandom_range(1, nlab));
        if ($urandom_range(99) < 65) it.pred = it.refl;
        else if ($urandom_range(99) < 80) it.pred = 4'($urandom_range(0, nlab));
      end else if (sel < 930) begin
        it.op = OP_READ;
        if ($urandom_range(99) < 70) begin
          it.rr = 4'($urandom_range(0, nlab));
          it.rc = 4'($urandom_range(0, nlab));
        end
      end else if (sel < 985) begin
        it.op = OP_FINISH;
      end else begin
        it.op = OP_CLEAR;
        nlab = $urandom_range(1, 15);
      end
      send_beat(it);
    end
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
